### hw/rtl/scbd_pkg.sv
// ----------------------------------------------------------------------------
// scbd_pkg: shared constants and the byte-wide CRC step
// Sync pattern, fixed header offsets, status and kind codes, and the
// unrolled reflected CRC-32 update for one byte.
// ----------------------------------------------------------------------------
package scbd_pkg;

  // default header size in bytes, counted from the first sync byte
  localparam int HdrBytesDef = 28;

  // sync sequence
  localparam logic [7:0] Sync0 = 8'hAA;
  localparam logic [7:0] Sync1 = 8'h44;
  localparam logic [7:0] Sync2 = 8'h12;
  localparam logic [15:0] SyncHist = {Sync0, Sync1};

  // fixed header offsets
  localparam logic [16:0] OfsSync2 = 17'd2;
  localparam logic [16:0] OfsAfterSync = 17'd3;
  localparam logic [16:0] OfsIdLo = 17'd4;
  localparam logic [16:0] OfsIdHi = 17'd5;
  localparam logic [16:0] OfsLenLo = 17'd8;
  localparam logic [16:0] OfsLenHi = 17'd9;

  // configuration register indexes
  localparam logic CfgPoly = 1'b0;
  localparam logic CfgMaxLen = 1'b1;

  // reset values of the configuration registers
  localparam logic [31:0] PolyDef = 32'hEDB88320;
  localparam logic [15:0] MaxLenDef = 16'hFFFF;

  // result kinds
  localparam logic KindByte = 1'b0;
  localparam logic KindEnd = 1'b1;

  // end report status
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StCrcErr = 2'd1;
  localparam logic [1:0] StTooLong = 2'd2;

  // received crc byte lanes
  localparam logic [1:0] Lane0 = 2'd0;
  localparam logic [1:0] Lane1 = 2'd1;
  localparam logic [1:0] Lane2 = 2'd2;
  localparam logic [1:0] Lane3 = 2'd3;

  // one byte of reflected crc, lsb first, unrolled over eight bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                           input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/sync_crc32_binary_deframer_top.sv
// ----------------------------------------------------------------------------
// sync_crc32_binary_deframer_top: sync-marked binary frame deframer
// Hunts for AA 44 12, passes on header and payload bytes with their offset,
// checks a trailing little-endian reflected CRC-32 and reports frame status.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                                      | tuser
//  ---------+-----+--------------------------------------------+-----------
//  in_      | in  | rx_byte                                    | -
//  out_     | out | frame_byte, byte_offset, message_id,       | item_kind
//           |     | payload_len, frame_status (+5 zero bits)   |
//  cfg_     | in  | cfg_wdata to register cfg_addr             | -
//
// One byte per cycle unless stalled; parse state and the result register load
// at the input transfer edge, so a result is offered from the next cycle.
// A write to crc_poly holds in_tready low, counted down by settle_r, while the
// cached CRC of the first two sync bytes is recomputed; the same hold follows reset.
// Input also stalls while a result waits in the output register unread.
// Reset (rst_n low, synchronous) returns to hunting with empty sync history.
module sync_crc32_binary_deframer_top
  import scbd_pkg::*;
#(
  parameter int HEADER_BYTES = HdrBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] frame_byte, [24:8] byte_offset,
                                  // [40:25] message_id, [56:41] payload_len,
                                  // [58:57] frame_status, [63:59] zero
  output logic        out_tuser,  // [0] item_kind
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // parse phases
  localparam logic [1:0] PhHunt = 2'd0;
  localparam logic [1:0] PhHead = 2'd1;
  localparam logic [1:0] PhBody = 2'd2;
  localparam logic [1:0] PhCrc  = 2'd3;

  localparam logic [1:0] PolySettle = 2'd2;
  localparam logic [16:0] HdrLen = 17'(HEADER_BYTES);

  // configuration
  logic [31:0] poly_r;
  logic [15:0] max_len_r;
  logic [1:0]  settle_r;
  logic [31:0] crc_aa_r;
  logic [31:0] crc_aa44_r;

  // parse state
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] hist_r, hist_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic [15:0] mid_r, mid_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rx_crc_r, rx_crc_nxt;

  // result register
  logic        out_valid_r;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic [16:0] out_off_r, out_off_nxt;
  logic [15:0] out_mid_r;
  logic [15:0] out_len_r;
  logic [1:0]  out_stat_r, out_stat_nxt;
  logic        emit;

  logic        in_xfer;
  logic [7:0]  b;
  logic [16:0] pos_inc;
  logic [16:0] body_end;
  logic [1:0]  lane;
  logic [31:0] crc_step;

  assign in_tready = (settle_r == 2'd0) && (!out_valid_r || out_tready);
  assign in_xfer = in_tvalid && in_tready;
  assign b = in_tdata;
  assign pos_inc = pos_r + 17'd1;
  assign body_end = HdrLen + {1'b0, len_r};
  assign lane = pos_r[1:0] - body_end[1:0];
  assign crc_step = crc_byte(crc_r, b, poly_r);

  // configuration registers and cached crc over the first two sync bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= PolyDef;
      max_len_r <= MaxLenDef;
      settle_r <= PolySettle;
    end else begin
      if (cfg_we && cfg_addr == CfgPoly) begin
        poly_r <= cfg_wdata;
        settle_r <= PolySettle;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
      if (cfg_we && cfg_addr == CfgMaxLen) begin
        max_len_r <= cfg_wdata[15:0];
      end
    end
    crc_aa_r <= crc_byte(32'd0, Sync0, poly_r);
    crc_aa44_r <= crc_byte(crc_aa_r, Sync1, poly_r);
  end

  // byte parser
  always_comb begin
    phase_nxt = phase_r;
    hist_nxt = hist_r;
    pos_nxt = pos_r;
    mid_nxt = mid_r;
    len_nxt = len_r;
    crc_nxt = crc_r;
    rx_crc_nxt = rx_crc_r;
    emit = 1'b0;
    out_kind_nxt = KindByte;
    out_byte_nxt = b;
    out_off_nxt = pos_r;
    out_stat_nxt = StOk;
    case (phase_r)
      PhHead: begin
        if (pos_r == OfsIdLo) mid_nxt = {mid_r[15:8], b};
        if (pos_r == OfsIdHi) mid_nxt = {b, mid_r[7:0]};
        if (pos_r == OfsLenLo) len_nxt = {len_r[15:8], b};
        if (pos_r == OfsLenHi) len_nxt = {b, len_r[7:0]};
        emit = 1'b1;
        if (pos_r == OfsLenHi && len_nxt > max_len_r) begin
          // oversized frame: report and drop
          out_kind_nxt = KindEnd;
          out_byte_nxt = 8'd0;
          out_stat_nxt = StTooLong;
          phase_nxt = PhHunt;
          hist_nxt = 16'd0;
        end else begin
          crc_nxt = crc_step;
          pos_nxt = pos_inc;
          if (pos_inc >= HdrLen) begin
            rx_crc_nxt = 32'd0;
            phase_nxt = (len_nxt == 16'd0) ? PhCrc : PhBody;
          end
        end
      end
      PhBody: begin
        crc_nxt = crc_step;
        pos_nxt = pos_inc;
        emit = 1'b1;
        if (pos_inc >= body_end) begin
          rx_crc_nxt = 32'd0;
          phase_nxt = PhCrc;
        end
      end
      PhCrc: begin
        case (lane)
          Lane0:   rx_crc_nxt[7:0] = b;
          Lane1:   rx_crc_nxt[15:8] = b;
          Lane2:   rx_crc_nxt[23:16] = b;
          Lane3:   rx_crc_nxt[31:24] = b;
          default: rx_crc_nxt = rx_crc_r;
        endcase
        pos_nxt = pos_inc;
        if (lane == Lane3) begin
          emit = 1'b1;
          out_kind_nxt = KindEnd;
          out_byte_nxt = 8'd0;
          out_stat_nxt = (rx_crc_nxt == crc_r) ? StOk : StCrcErr;
          phase_nxt = PhHunt;
          hist_nxt = 16'd0;
        end
      end
      default: begin
        // hunting
        if (hist_r == SyncHist && b == Sync2) begin
          mid_nxt = 16'd0;
          len_nxt = 16'd0;
          rx_crc_nxt = 32'd0;
          crc_nxt = crc_byte(crc_aa44_r, Sync2, poly_r);
          hist_nxt = 16'd0;
          pos_nxt = OfsAfterSync;
          phase_nxt = PhHead;
          emit = 1'b1;
          out_off_nxt = OfsSync2;
        end else begin
          phase_nxt = PhHunt;
          hist_nxt = {hist_r[7:0], b};
        end
      end
    endcase
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhHunt;
      hist_r <= 16'd0;
      pos_r <= 17'd0;
      mid_r <= 16'd0;
      len_r <= 16'd0;
      crc_r <= 32'd0;
      rx_crc_r <= 32'd0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      hist_r <= hist_nxt;
      pos_r <= pos_nxt;
      mid_r <= mid_nxt;
      len_r <= len_nxt;
      crc_r <= crc_nxt;
      rx_crc_r <= rx_crc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (in_xfer && emit) begin
      out_kind_r <= out_kind_nxt;
      out_byte_r <= out_byte_nxt;
      out_off_r <= out_off_nxt;
      out_mid_r <= mid_nxt;
      out_len_r <= len_nxt;
      out_stat_r <= out_stat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_kind_r;
  assign out_tdata = {5'd0, out_stat_r, out_len_r, out_mid_r, out_off_r, out_byte_r};

  // a completed sync moves the parser into the header
  a_sync_to_head: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && phase_r == PhHunt && hist_r == SyncHist && b == Sync2)
      |=> (phase_r == PhHead && pos_r == OfsAfterSync))
    else $error("sync did not enter header phase");

  // frame bytes never carry a status
  a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KindByte) |-> (out_stat_r == StOk))
    else $error("frame byte with nonzero status");

  // a crc verdict comes only after a full header and the four crc bytes
  a_end_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KindEnd && out_stat_r != StTooLong)
      |-> (out_off_r >= HdrLen + 17'd3))
    else $error("crc report before end of frame");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stream test of the sync-marked frame deframer
// Feeds byte streams of well-formed frames, bad-crc frames, over-length
// frames, broken frames and noise, with random gaps and output stalls.
// A scoreboard predicts every result from its own copy of the parse state
// and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module tb_top
  import scbd_pkg::*;
();

  localparam int CycleLimit = 100000;

  // parse phases of the predictor
  typedef enum logic [1:0] {
    SEEK_SYNC,
    IN_HEADER,
    IN_PAYLOAD,
    IN_CRC
  } parse_phase_t;

  // one expected result
  typedef struct packed {
    logic        kind;
    logic [7:0]  fbyte;
    logic [16:0] offset;
    logic [15:0] msg_id;
    logic [15:0] plen;
    logic [1:0]  status;
  } frame_item_t;

  // byte-level predictor and queue of results still due
  class deframe_scoreboard;
    logic [31:0]  poly;
    logic [15:0]  max_len;
    parse_phase_t phase;
    logic [15:0]  sync_hist;
    logic [16:0]  position;
    logic [15:0]  msg_id;
    logic [15:0]  plen;
    logic [31:0]  crc;
    logic [31:0]  rx_crc;
    frame_item_t  due_items[$];
    int           errors;

    function new();
      poly      = PolyDef;
      max_len   = MaxLenDef;
      phase     = SEEK_SYNC;
      sync_hist = '0;
      position  = '0;
      msg_id    = '0;
      plen      = '0;
      crc       = '0;
      rx_crc    = '0;
      errors    = 0;
    endfunction

    static function logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b,
                                          input logic [31:0] p);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ p) : (r >> 1);
      return r;
    endfunction

    function void set_reg(input logic idx, input logic [31:0] data);
      if (idx == CfgPoly) begin
        poly = data;
      end else begin
        max_len = data[15:0];
      end
    endfunction

    function void push(input logic kind, input logic [7:0] b, input logic [16:0] off,
                       input logic [1:0] st);
      frame_item_t it;
      it.kind   = kind;
      it.fbyte  = b;
      it.offset = off;
      it.msg_id = msg_id;
      it.plen   = plen;
      it.status = st;
      due_items.push_back(it);
    endfunction

    // note one accepted input byte and queue any result it causes
    function void take_byte(input logic [7:0] b);
      logic [16:0] pos;
      logic [16:0] body_end;
      logic [1:0]  lane;
      pos      = position;
      body_end = 17'(HdrBytesDef) + {1'b0, plen};
      case (phase)
        IN_HEADER: begin
          if (pos == OfsIdLo) msg_id[7:0] = b;
          if (pos == OfsIdHi) msg_id[15:8] = b;
          if (pos == OfsLenLo) plen[7:0] = b;
          if (pos == OfsLenHi) begin
            plen[15:8] = b;
            // over-length frame ends right here
            if (plen > max_len) begin
              push(KindEnd, 8'd0, pos, StTooLong);
              phase     = SEEK_SYNC;
              sync_hist = '0;
              return;
            end
          end
          crc      = crc_step(crc, b, poly);
          position = pos + 17'd1;
          if (position >= 17'(HdrBytesDef)) begin
            rx_crc = '0;
            phase  = (plen == 16'd0) ? IN_CRC : IN_PAYLOAD;
          end
          push(KindByte, b, pos, StOk);
        end
        IN_PAYLOAD: begin
          crc      = crc_step(crc, b, poly);
          position = pos + 17'd1;
          if (position >= body_end) begin
            rx_crc = '0;
            phase  = IN_CRC;
          end
          push(KindByte, b, pos, StOk);
        end
        IN_CRC: begin
          lane     = 2'(pos - body_end);
          rx_crc   = rx_crc | ({24'd0, b} << (8 * lane));
          position = pos + 17'd1;
          if (lane == Lane3) begin
            push(KindEnd, 8'd0, pos, (rx_crc == crc) ? StOk : StCrcErr);
            phase     = SEEK_SYNC;
            sync_hist = '0;
          end
        end
        default: begin
          if (sync_hist == SyncHist && b == Sync2) begin
            msg_id    = '0;
            plen      = '0;
            rx_crc    = '0;
            crc       = crc_step(crc_step(crc_step('0, Sync0, poly), Sync1, poly), Sync2, poly);
            sync_hist = '0;
            position  = OfsAfterSync;
            phase     = IN_HEADER;
            push(KindByte, b, OfsSync2, StOk);
          end else begin
            phase     = SEEK_SYNC;
            sync_hist = {sync_hist[7:0], b};
          end
        end
      endcase
    endfunction

    function void compare(input string name, input logic [31:0] exp_v,
                          input logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // check one output transfer against the oldest due result
    function void check_item(input logic [63:0] data, input logic user);
      frame_item_t e;
      if (due_items.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual data %0h kind %0h",
                 $time, data, user);
        errors++;
        return;
      end
      e = due_items.pop_front();
      compare("item_kind", 32'(e.kind), 32'(user));
      compare("frame_byte", 32'(e.fbyte), 32'(data[7:0]));
      compare("byte_offset", 32'(e.offset), 32'(data[24:8]));
      compare("message_id", 32'(e.msg_id), 32'(data[40:25]));
      compare("payload_len", 32'(e.plen), 32'(data[56:41]));
      compare("frame_status", 32'(e.status), 32'(data[58:57]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [7:0] frame_byte, [24:8] byte_offset, [40:25] message_id,
                           // [56:41] payload_len, [58:57] frame_status
  logic        out_tuser;  // [0] item_kind
  logic        cfg_we;
  logic        cfg_addr;
  logic [31:0] cfg_wdata;

  deframe_scoreboard chk;
  bit                no_idle;
  int                gap_pct;
  int                sent_count;
  int                cycles = 0;

  sync_crc32_binary_deframer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) chk.take_byte(in_tdata);
      if (out_tvalid && out_tready) chk.check_item(out_tdata, out_tuser);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stalls in random bursts
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // one input transfer, with an optional gap in front
  task automatic send_byte(input logic [7:0] b);
    if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // stop sending and wait until every due result has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chk.due_items.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    chk.set_reg(idx, data);
  endtask

  // sync, header, payload and crc of one frame; over-length frames stop
  // after the length bytes
  task automatic build_frame(input logic [15:0] id, input logic [15:0] len,
                             input logic [31:0] crc_flip, input bit plant_sync,
                             output logic [7:0] fq[$]);
    logic [31:0] crc;
    logic [7:0]  b;
    fq = '{Sync0, Sync1, Sync2};
    for (int i = int'(OfsAfterSync); i < HdrBytesDef; i++) begin
      case (17'(i))
        OfsIdLo:  b = id[7:0];
        OfsIdHi:  b = id[15:8];
        OfsLenLo: b = len[7:0];
        OfsLenHi: b = len[15:8];
        default:  b = 8'($urandom);
      endcase
      fq.push_back(b);
    end
    if (len > chk.max_len) begin
      fq = fq[0:int'(OfsLenHi)];
      return;
    end
    for (int i = 0; i < int'(len); i++) fq.push_back(8'($urandom));
    // a sync pattern inside the payload must not restart the frame
    if (plant_sync && len >= 16'd3) begin
      fq[HdrBytesDef]     = Sync0;
      fq[HdrBytesDef + 1] = Sync1;
      fq[HdrBytesDef + 2] = Sync2;
    end
    crc = '0;
    foreach (fq[i]) crc = deframe_scoreboard::crc_step(crc, fq[i], chk.poly);
    crc ^= crc_flip;
    for (int k = 0; k < 4; k++) fq.push_back(crc[8*k +: 8]);
  endtask

  // stimulus
  initial begin
    logic [7:0]  fq[$];
    logic [31:0] phase_poly[4];
    logic [15:0] phase_max[4];
    logic [15:0] len;
    logic [31:0] flip;
    logic [7:0]  b;
    int          cap;
    int          pick;
    int          target;
    int          cut;

    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = CfgPoly;
    cfg_wdata  = '0;
    rst_n      = 1'b0;
    no_idle    = 1'b0;
    gap_pct    = 20;
    sent_count = 0;
    chk        = new();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // noise with a near-miss sync, then a frame behind a repeated first sync byte
    send_bytes('{8'h00, 8'hFF, Sync0, Sync1, 8'h13, Sync0});
    build_frame(16'hFFFF, 16'd0, 32'd0, 1'b0, fq);
    send_bytes(fq);
    // bad crc, then a lone last sync byte with empty history
    build_frame(16'h0000, 16'd1, 32'h0000_0001, 1'b0, fq);
    send_bytes(fq);
    send_byte(Sync2);
    // long payload carrying a sync pattern
    build_frame(16'($urandom), 16'd100, 32'd0, 1'b1, fq);
    send_bytes(fq);

    // polynomial changed in the middle of a frame
    build_frame(16'h1234, 16'd2, 32'd0, 1'b0, fq);
    send_bytes(fq[0:11]);
    settle();
    write_reg(CfgPoly, 32'h82F6_3B78);
    send_bytes(fq[12:$]);

    // length limit: at the limit, above it, and the largest length
    settle();
    write_reg(CfgMaxLen, 32'd3);
    build_frame(16'h00A5, 16'd3, 32'd0, 1'b0, fq);
    send_bytes(fq);
    build_frame(16'h5A00, 16'd4, 32'd0, 1'b0, fq);
    send_bytes(fq);
    build_frame(16'h8001, 16'hFFFF, 32'd0, 1'b0, fq);
    send_bytes(fq);

    // random phases, each with its own register setting
    phase_poly = '{PolyDef, 32'h82F6_3B78, 32'h0000_0000, 32'hFFFF_FFFF};
    phase_max  = '{MaxLenDef, 16'd0, 16'($urandom_range(1, 12)), 16'($urandom_range(13, 40))};
    sent_count = 0;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_reg(CfgPoly, phase_poly[ph]);
      write_reg(CfgMaxLen, {16'd0, phase_max[ph]});
      no_idle = (ph == 3);
      target  = sent_count + ((ph == 3) ? 70 : 95);
      while (sent_count < target) begin
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
        pick    = $urandom_range(0, 9);
        cap     = ($urandom_range(0, 7) == 0) ? 60 : 12;
        if (int'(chk.max_len) < cap) cap = int'(chk.max_len);
        len     = 16'($urandom_range(0, cap));
        flip    = '0;
        if (pick == 6) flip = 32'd1 << $urandom_range(0, 31);
        if (pick == 7 && chk.max_len != 16'hFFFF) begin
          len = 16'($urandom_range(int'(chk.max_len) + 1, 65535));
        end
        if (pick <= 7) begin
          build_frame(16'($urandom), len, flip, 1'($urandom_range(0, 1)), fq);
          send_bytes(fq);
        end else if (pick == 9 && chk.max_len < 16'd256) begin
          // frame cut short, the next bytes fill it up
          build_frame(16'($urandom), len, flip, 1'b0, fq);
          cut = $urandom_range(3, fq.size() - 1);
          send_bytes(fq[0:cut - 1]);
        end else begin
          // noise rich in partial sync patterns
          repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 3))
              0:       b = Sync0;
              1:       b = Sync1;
              default: b = 8'($urandom);
            endcase
            if (b == Sync2) b = 8'h13;
            send_byte(b);
          end
        end
      end
    end

    // drain and report
    settle();
    repeat (8) @(posedge clk);
    if (chk.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
